// File: rtl/core/mqttd_pkg.sv
// Package for the MQTT packet deframer core.
// Holds parse phase codes, widths and reset values; no dependencies.
`default_nettype none

package mqttd_pkg;

  // Parse phase codes
  typedef logic [1:0] phase_t;
  localparam phase_t PH_TYPE    = 2'd0;
  localparam phase_t PH_LEN     = 2'd1;
  localparam phase_t PH_PAYLOAD = 2'd2;
  localparam phase_t PH_DROP    = 2'd3;

  // Header holds the type byte plus up to four length bytes
  localparam int unsigned HDR_DEPTH = 5;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned LEN_W     = 28;
  localparam int unsigned MAX_W     = 16;

  typedef logic [7:0]       byte_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [LEN_W-1:0] len_t;

  localparam logic [MAX_W-1:0] MAX_PKT_RESET = 16'd1024;

endpackage

`default_nettype wire

// File: rtl/core/mqtt_packet_deframer_core.sv
// MQTT packet deframer top level: byte-stream parser and result emitter.
// Depends on mqttd_pkg.
`default_nettype none

// Accepts one stream byte per cycle and splits the stream into MQTT packets by
// decoding the variable-length remaining-length field. Type and length bytes
// are held until the length is complete, then released as a burst of up to
// five results, one per cycle while out_tready is high; payload bytes pass
// through the registered emit buffer. A request is taken every cycle except
// while a header burst drains: the input stalls until the emit buffer is on
// its last result and that result is taken. A continuation bit on the fourth
// length byte or a total length above cfg max gives one error result,
// and the rest of that chunk (up to in_tlast) is dropped.
module mqtt_packet_deframer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: max_packet_bytes
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // chunk_end
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic [2:0]       out_tuser,  // [0] is_error, [1] packet_start, [2] packet_end
  output logic             out_tlast   // run_last
);

  // Parser state
  logic [mqttd_pkg::MAX_W-1:0] max_pkt_r;
  mqttd_pkg::phase_t phase_r, phase_nxt;
  mqttd_pkg::byte_t  hdr_r [mqttd_pkg::HDR_DEPTH];
  mqttd_pkg::cnt_t   hcnt_r, hcnt_nxt;
  mqttd_pkg::len_t   acc_r, acc_nxt;
  logic [1:0]        gidx_r, gidx_nxt;
  mqttd_pkg::len_t   left_r, left_nxt;

  // Emit buffer
  mqttd_pkg::byte_t  ebuf_r [mqttd_pkg::HDR_DEPTH];
  mqttd_pkg::byte_t  ebuf_nxt [mqttd_pkg::HDR_DEPTH];
  mqttd_pkg::cnt_t   erem_r, erem_nxt;
  mqttd_pkg::cnt_t   eidx_r, eidx_nxt;
  logic              eerr_r, eerr_nxt;
  logic              estart_r, estart_nxt;
  logic              eend_r, eend_nxt;
  logic              eload;

  logic              in_fire, out_fire;
  mqttd_pkg::len_t   acc_new, grp;
  mqttd_pkg::cnt_t   hcnt_inc;
  logic [mqttd_pkg::LEN_W:0] total;
  logic              too_long;

  assign in_tready = (erem_r == '0) || ((erem_r == mqttd_pkg::cnt_t'(1)) && out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  // Length group placed at 7 * group index
  always_comb begin
    case (gidx_r)
      2'd0:    grp = {21'b0, in_tdata[6:0]};
      2'd1:    grp = {14'b0, in_tdata[6:0], 7'b0};
      2'd2:    grp = {7'b0, in_tdata[6:0], 14'b0};
      default: grp = {in_tdata[6:0], 21'b0};
    endcase
  end

  assign acc_new  = acc_r | grp;
  assign hcnt_inc = hcnt_r + mqttd_pkg::cnt_t'(1);
  assign total    = {1'b0, acc_new} + {{(mqttd_pkg::LEN_W + 1 - mqttd_pkg::CNT_W){1'b0}}, hcnt_inc};
  assign too_long = total > {{(mqttd_pkg::LEN_W + 1 - mqttd_pkg::MAX_W){1'b0}}, max_pkt_r};

  // Next-state and emit-load logic
  always_comb begin
    phase_nxt  = phase_r;
    hcnt_nxt   = hcnt_r;
    acc_nxt    = acc_r;
    gidx_nxt   = gidx_r;
    left_nxt   = left_r;
    erem_nxt   = erem_r;
    eidx_nxt   = eidx_r;
    eerr_nxt   = eerr_r;
    estart_nxt = estart_r;
    eend_nxt   = eend_r;
    eload      = 1'b0;
    for (int i = 0; i < mqttd_pkg::HDR_DEPTH; i++) begin
      ebuf_nxt[i] = (i < int'(hcnt_r)) ? hdr_r[i] : in_tdata;
    end

    // drain one result
    if (out_fire) begin
      erem_nxt = erem_r - mqttd_pkg::cnt_t'(1);
      eidx_nxt = eidx_r + mqttd_pkg::cnt_t'(1);
    end

    if (in_fire) begin
      case (phase_r)
        mqttd_pkg::PH_DROP: begin
          if (in_tlast) phase_nxt = mqttd_pkg::PH_TYPE;
        end
        mqttd_pkg::PH_TYPE: begin
          hcnt_nxt  = mqttd_pkg::cnt_t'(1);
          acc_nxt   = '0;
          gidx_nxt  = '0;
          phase_nxt = mqttd_pkg::PH_LEN;
        end
        mqttd_pkg::PH_LEN: begin
          hcnt_nxt = hcnt_inc;
          acc_nxt  = acc_new;
          if ((in_tdata[7] && (gidx_r == 2'd3)) || (!in_tdata[7] && too_long)) begin
            // malformed: one error result, then resync
            eload       = 1'b1;
            erem_nxt    = mqttd_pkg::cnt_t'(1);
            eidx_nxt    = '0;
            eerr_nxt    = 1'b1;
            estart_nxt  = 1'b0;
            eend_nxt    = 1'b0;
            ebuf_nxt[0] = '0;
            hcnt_nxt    = '0;
            acc_nxt     = '0;
            gidx_nxt    = '0;
            left_nxt    = '0;
            phase_nxt   = in_tlast ? mqttd_pkg::PH_TYPE : mqttd_pkg::PH_DROP;
          end else if (in_tdata[7]) begin
            gidx_nxt = gidx_r + 2'd1;
          end else begin
            // header complete: release held bytes plus this one
            eload      = 1'b1;
            erem_nxt   = hcnt_inc;
            eidx_nxt   = '0;
            eerr_nxt   = 1'b0;
            estart_nxt = 1'b1;
            eend_nxt   = (acc_new == '0);
            left_nxt   = acc_new;
            hcnt_nxt   = '0;
            gidx_nxt   = '0;
            phase_nxt  = (acc_new == '0) ? mqttd_pkg::PH_TYPE : mqttd_pkg::PH_PAYLOAD;
          end
        end
        default: begin
          // payload byte passes straight through
          eload       = 1'b1;
          erem_nxt    = mqttd_pkg::cnt_t'(1);
          eidx_nxt    = '0;
          eerr_nxt    = 1'b0;
          estart_nxt  = 1'b0;
          eend_nxt    = (left_r <= mqttd_pkg::len_t'(1));
          ebuf_nxt[0] = in_tdata;
          if (left_r <= mqttd_pkg::len_t'(1)) begin
            left_nxt  = '0;
            phase_nxt = mqttd_pkg::PH_TYPE;
          end else begin
            left_nxt  = left_r - mqttd_pkg::len_t'(1);
          end
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pkt_r <= mqttd_pkg::MAX_PKT_RESET;
      phase_r   <= mqttd_pkg::PH_TYPE;
      hcnt_r    <= '0;
      acc_r     <= '0;
      gidx_r    <= '0;
      left_r    <= '0;
      erem_r    <= '0;
      eidx_r    <= '0;
      eerr_r    <= 1'b0;
      estart_r  <= 1'b0;
      eend_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) max_pkt_r <= cfg_wr_data;
      phase_r  <= phase_nxt;
      hcnt_r   <= hcnt_nxt;
      acc_r    <= acc_nxt;
      gidx_r   <= gidx_nxt;
      left_r   <= left_nxt;
      erem_r   <= erem_nxt;
      eidx_r   <= eidx_nxt;
      eerr_r   <= eerr_nxt;
      estart_r <= estart_nxt;
      eend_r   <= eend_nxt;
    end
  end

  // Header hold and emit buffer data (no reset)
  always_ff @(posedge clk) begin
    if (in_fire && (phase_r == mqttd_pkg::PH_TYPE)) hdr_r[0] <= in_tdata;
    if (in_fire && (phase_r == mqttd_pkg::PH_LEN) && (hcnt_r < mqttd_pkg::cnt_t'(mqttd_pkg::HDR_DEPTH)))
      hdr_r[hcnt_r] <= in_tdata;
    if (eload) begin
      for (int i = 0; i < mqttd_pkg::HDR_DEPTH; i++) ebuf_r[i] <= ebuf_nxt[i];
    end
  end

  // Result outputs
  assign out_tvalid   = (erem_r != '0);
  assign out_tdata    = ebuf_r[eidx_r];
  assign out_tlast    = (erem_r == mqttd_pkg::cnt_t'(1));
  assign out_tuser[0] = eerr_r;
  assign out_tuser[1] = estart_r && (eidx_r == '0);
  assign out_tuser[2] = eend_r && (erem_r == mqttd_pkg::cnt_t'(1));

  // Checks
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tlast && (out_tdata == 8'd0) && !out_tuser[1]))
    else $error("error result must be a single zero result");

  a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (erem_r <= mqttd_pkg::cnt_t'(1)))
    else $error("input accepted while emit burst pending");

  a_burst_len: assert property (@(posedge clk) disable iff (!rst_n)
    erem_r <= mqttd_pkg::cnt_t'(mqttd_pkg::HDR_DEPTH))
    else $error("emit burst longer than header depth");

  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != mqttd_pkg::PH_LEN) |-> (hcnt_r == '0 || phase_r == mqttd_pkg::PH_TYPE))
    else $error("held header count outside length phase");

endmodule

`default_nettype wire
